@@ rtl/core/u8s_pkg.sv @@
// Package for the UTF-8 string run scanner.
// Holds shared constants, register and mode codes, and the front-to-back event type.
// No dependencies.
`default_nettype none

package u8s_pkg;

    // Default widths of the offset and length counters
    localparam int OFFSET_BITS_DEF = 48;
    localparam int LENGTH_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MIN_LEN_W   = 16;
    localparam int MODE_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_MODE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INCLUDE_WS   = 2'd2;

    localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST = 16'd4;

    // Character class modes
    localparam logic [MODE_W-1:0] MODE_ALNUM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRINT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_IDENT = 2'd3;

    // Input actions
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Depth of the event queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Event handed from the decoder to the run tracker.
    // do_end closes the current run first; do_take then extends a run.
    typedef struct packed {
        logic       do_end;
        logic       do_take;
        logic [2:0] len;
        logic       non_ascii;
    } ev_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/u8s_queue.sv @@
// Small register FIFO that decouples the decoder from the run tracker.
// Depends on nothing but its parameters.
`default_nettype none

module u8s_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/u8s_front.sv @@
// Front end: accepts bytes, tracks the byte offset and decodes UTF-8 sequences.
// Emits end/take events for the run tracker. Uses u8s_pkg.
`default_nettype none

module u8s_front
    import u8s_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   action,
    input  wire logic [7:0]             byte_value,
    input  wire logic [MODE_W-1:0]      char_mode,
    input  wire logic                   include_ws,
    input  wire logic                   q_full,
    output logic                        push,
    output ev_ctrl_t                    ev,
    output logic [OFFSET_BITS-1:0]      ev_start
);

    function automatic logic ascii_ok(logic [6:0] c, logic [MODE_W-1:0] mode, logic ws_en);
        logic alnum;
        logic ws;
        logic prt;
        logic ok;
        alnum = (c inside {[7'h30:7'h39], [7'h41:7'h5A], [7'h61:7'h7A]});
        ws    = (c == 7'h20) || (c == 7'h09);
        prt   = (c inside {[7'h20:7'h7E]});
        case (mode)
            MODE_ALNUM: ok = alnum || (ws_en && ws);
            MODE_PRINT: ok = prt;
            MODE_TEXT:  ok = ws_en ? (prt || ws) : (c inside {[7'h21:7'h7E]});
            MODE_IDENT: ok = alnum || (c == 7'h5F);
            default:    ok = prt;
        endcase
        return ok;
    endfunction

    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [20:0]            val_reg, val_next;
    logic [1:0]             needed_reg, needed_next;
    logic [1:0]             got_reg, got_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;

    logic       accept;
    logic       lead_take;
    logic       lead_open;
    logic [1:0] lead_need;
    logic [20:0] lead_val;
    logic [1:0] got_inc;
    logic [20:0] cp;
    logic       bad;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the byte as a lead byte
    always_comb
    begin
        lead_take = 1'b0;
        lead_open = 1'b0;
        lead_need = 2'd0;
        lead_val  = '0;
        if (!byte_value[7])
        begin
            lead_take = (byte_value != 8'h00) &&
                        ascii_ok(byte_value[6:0], char_mode, include_ws);
        end
        else if (byte_value inside {[8'hC2:8'hDF]})
        begin
            lead_open = 1'b1;
            lead_need = 2'd1;
            lead_val  = {16'd0, byte_value[4:0]};
        end
        else if (byte_value inside {[8'hE0:8'hEF]})
        begin
            lead_open = 1'b1;
            lead_need = 2'd2;
            lead_val  = {17'd0, byte_value[3:0]};
        end
        else if (byte_value inside {[8'hF0:8'hF4]})
        begin
            lead_open = 1'b1;
            lead_need = 2'd3;
            lead_val  = {18'd0, byte_value[2:0]};
        end
    end

    always_comb
    begin
        off_next    = off_reg;
        val_next    = val_reg;
        needed_next = needed_reg;
        got_next    = got_reg;
        pstart_next = pstart_reg;
        ev          = '0;
        ev_start    = off_reg;
        got_inc     = got_reg + 1'b1;
        cp          = {val_reg[14:0], byte_value[5:0]};
        bad         = ((needed_reg == 2'd1) && (cp < 21'h80)) ||
                      ((needed_reg == 2'd2) && (cp < 21'h800)) ||
                      ((needed_reg == 2'd3) && (cp < 21'h10000)) ||
                      (cp > 21'h10FFFF) ||
                      ((cp >= 21'hD800) && (cp <= 21'hDFFF));
        if (accept)
        begin
            if (action == ACT_FLUSH)
            begin
                // End of data: close the run, drop any open sequence
                ev.do_end   = 1'b1;
                needed_next = 2'd0;
                got_next    = 2'd0;
            end
            else
            begin
                off_next = off_reg + 1'b1;
                if ((needed_reg == 2'd0) || (byte_value[7:6] != 2'b10))
                begin
                    // Broken sequence ends the run, then the byte acts as a lead
                    if (needed_reg != 2'd0)
                    begin
                        ev.do_end = 1'b1;
                    end
                    needed_next = 2'd0;
                    got_next    = 2'd0;
                    if (lead_take)
                    begin
                        ev.do_take = 1'b1;
                        ev.len     = 3'd1;
                    end
                    else if (lead_open)
                    begin
                        needed_next = lead_need;
                        val_next    = lead_val;
                        pstart_next = off_reg;
                    end
                    else
                    begin
                        ev.do_end = 1'b1;
                    end
                end
                else
                begin
                    val_next = cp;
                    if (got_inc < needed_reg)
                    begin
                        got_next = got_inc;
                    end
                    else
                    begin
                        needed_next = 2'd0;
                        got_next    = 2'd0;
                        if (!bad && (char_mode != MODE_IDENT))
                        begin
                            ev.do_take   = 1'b1;
                            ev.len       = {1'b0, needed_reg} + 3'd1;
                            ev.non_ascii = 1'b1;
                            ev_start     = pstart_reg;
                        end
                        else
                        begin
                            ev.do_end = 1'b1;
                        end
                    end
                end
            end
        end
        push = ev.do_end || ev.do_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= '0;
            needed_reg <= '0;
            got_reg    <= '0;
        end
        else
        begin
            off_reg    <= off_next;
            needed_reg <= needed_next;
            got_reg    <= got_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        pstart_reg <= pstart_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/u8s_back.sv @@
// Back end: run tracker with saturating counters and the result register.
// Consumes events from the queue. Uses u8s_pkg.
`default_nettype none

module u8s_back
    import u8s_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire ev_ctrl_t               ev,
    input  wire logic [OFFSET_BITS-1:0] ev_start,
    output logic                        pop,
    input  wire logic [MIN_LEN_W-1:0]   min_length,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OFFSET_BITS-1:0]      start_offset,
    output logic [LENGTH_BITS-1:0]      byte_length,
    output logic [LENGTH_BITS-1:0]      char_length
);

    localparam int CMP_W = (LENGTH_BITS > MIN_LEN_W) ? LENGTH_BITS : MIN_LEN_W;

    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0] bytes_reg, bytes_next;
    logic [LENGTH_BITS-1:0] chars_reg, chars_next;
    logic                   na_reg, na_next;

    logic                   out_valid_reg;
    logic [OFFSET_BITS-1:0] out_start_reg;
    logic [LENGTH_BITS-1:0] out_bytes_reg;
    logic [LENGTH_BITS-1:0] out_chars_reg;

    logic                   qualify;
    logic [LENGTH_BITS:0]   bytes_sum;

    assign qualify = ev.do_end && na_reg &&
                     (CMP_W'(chars_reg) >= CMP_W'(min_length));
    assign pop = q_valid && (!qualify || !out_valid_reg || out_ready);

    always_comb
    begin
        start_next = start_reg;
        bytes_next = bytes_reg;
        chars_next = chars_reg;
        na_next    = na_reg;
        bytes_sum  = '0;
        if (pop)
        begin
            if (ev.do_end)
            begin
                bytes_next = '0;
                chars_next = '0;
                na_next    = 1'b0;
            end
            if (ev.do_take)
            begin
                if (chars_next == '0)
                begin
                    start_next = ev_start;
                end
                bytes_sum  = {1'b0, bytes_next} + (LENGTH_BITS + 1)'(ev.len);
                bytes_next = bytes_sum[LENGTH_BITS] ? '1 : bytes_sum[LENGTH_BITS-1:0];
                if (!(&chars_next))
                begin
                    chars_next = chars_next + 1'b1;
                end
                na_next = na_next || ev.non_ascii;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            bytes_reg     <= '0;
            chars_reg     <= '0;
            na_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            bytes_reg <= bytes_next;
            chars_reg <= chars_next;
            na_reg    <= na_next;
            if (pop && qualify)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && qualify)
        begin
            out_start_reg <= start_reg;
            out_bytes_reg <= bytes_reg;
            out_chars_reg <= chars_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign start_offset = out_start_reg;
    assign byte_length  = out_bytes_reg;
    assign char_length  = out_chars_reg;

endmodule

`default_nettype wire

@@ rtl/core/utf8_string_run_scanner.sv @@
// The item that ends a run passes the event queue, then sets the result register.
// Throughput: one item per cycle unless the queue is full; decoder, event queue and
// run tracker each move one item per cycle; the two-entry queue absorbs output stalls.
// Reset: rst_n clears offset, decoder and run state at once; min_length returns to 4,
// char_mode and include_whitespace to 0. No clearing pass is needed.
`default_nettype none

module utf8_string_run_scanner
    import u8s_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // Input items
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   action,
    input  wire logic [7:0]             byte_value,
    // Result items
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OFFSET_BITS-1:0]      start_offset,
    output logic [LENGTH_BITS-1:0]      byte_length,
    output logic [LENGTH_BITS-1:0]      char_length
);

    localparam int EV_W = $bits(ev_ctrl_t);
    localparam int Q_W  = OFFSET_BITS + EV_W;

    // Configuration registers: always ready, a write takes effect in the cycle after it is accepted
    logic [MIN_LEN_W-1:0] min_length_reg;
    logic [MODE_W-1:0]    char_mode_reg;
    logic                 include_ws_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RST;
            char_mode_reg  <= MODE_ALNUM;
            include_ws_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_LENGTH: min_length_reg <= cfg_data[MIN_LEN_W-1:0];
                CFG_CHAR_MODE:  char_mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_INCLUDE_WS: include_ws_reg <= cfg_data[0];
                default:        ; // unused index: drop the write
            endcase
        end
    end

    // Front: decode bytes into end/take events
    logic                   push;
    logic                   q_full;
    ev_ctrl_t               f_ev;
    logic [OFFSET_BITS-1:0] f_start;

    u8s_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .byte_value (byte_value),
        .char_mode  (char_mode_reg),
        .include_ws (include_ws_reg),
        .q_full     (q_full),
        .push       (push),
        .ev         (f_ev),
        .ev_start   (f_start)
    );

    // Queue: hold events while the result register is stalled
    logic           q_valid;
    logic           pop;
    logic [Q_W-1:0] q_head;
    ev_ctrl_t       b_ev;
    logic [OFFSET_BITS-1:0] b_start;

    u8s_queue #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_start, f_ev}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head_data (q_head)
    );

    assign b_ev    = q_head[EV_W-1:0];
    assign b_start = q_head[Q_W-1:EV_W];

    // Back: advance the run, report qualifying runs
    u8s_back #(
        .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .ev           (b_ev),
        .ev_start     (b_start),
        .pop          (pop),
        .min_length   (min_length_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .start_offset (start_offset),
        .byte_length  (byte_length),
        .char_length  (char_length)
    );

endmodule

`default_nettype wire

@@ rtl/core/u8s_checker.sv @@
// Port-level checks for the UTF-8 string run scanner, bound to its top level.
// Depends on u8s_pkg and utf8_string_run_scanner.
`default_nettype none

module u8s_checker
    import u8s_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [OFFSET_BITS-1:0] start_offset,
    input wire logic [LENGTH_BITS-1:0] byte_length,
    input wire logic [LENGTH_BITS-1:0] char_length
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(start_offset) &&
        $stable(byte_length) && $stable(char_length))
        else $error("result changed while stalled");

    // Empty runs are never reported
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_length != '0)
        else $error("empty run reported");

    // Every character takes at least one byte
    a_bytes_ge_chars: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_length >= char_length)
        else $error("byte length below char length");

    // A reported run holds a multibyte character
    a_multibyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_length >= LENGTH_BITS'(2))
        else $error("reported run without a multibyte character");

endmodule

bind utf8_string_run_scanner u8s_checker #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .start_offset (start_offset),
    .byte_length  (byte_length),
    .char_length  (char_length)
);

`default_nettype wire
